// ===== sv/tfb_pkg.sv =====
package tfb_pkg;

  localparam int FRAME_LENGTH_DEF = 64;
  localparam int QUEUE_DEPTH      = 2;
  localparam int PAYLOAD_END      = 40;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0]  SYNC_FIRST    = 8'h54;
  localparam logic [7:0]  SYNC_SECOND   = 8'h47;
  localparam logic [7:0]  FRAME_VERSION = 8'd3;
  localparam logic [7:0]  PAYLOAD_LEN   = 8'd40;
  localparam logic [7:0]  AMBIENT_OFFSET = 8'd10;

  localparam logic [16:0] HUMIDITY_MAX     = 17'd100000;
  localparam logic [9:0]  OUTPUT_MAX       = 10'd1000;
  localparam logic [6:0]  SETPOINT_HUM_MAX = 7'd100;

  localparam logic [1:0]  CFG_TARGET_TEMP = 2'd0;
  localparam logic [1:0]  CFG_TARGET_HUM  = 2'd1;

  typedef struct packed {
    logic [31:0] tick;
    logic [31:0] chamber_temp;
    logic [7:0]  ambient_ofs;
    logic [16:0] humidity;
    logic        reading_valid;
    logic [7:0]  status;
    logic [9:0]  heater;
    logic [7:0]  set_temp;
    logic [6:0]  set_hum;
    logic [7:0]  fault;
    logic [7:0]  ack_outcome;
    logic [31:0] ack_sess_id;
    logic [31:0] ack_seq_no;
    logic [31:0] rcv_err_cnt;
  } record_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // header and payload bytes, everything past the payload is zero
  function automatic logic [7:0] record_byte(input record_t rec, input logic [5:0] idx);
    logic [7:0] b;
    case (idx)
      6'd0:  b = SYNC_FIRST;
      6'd1:  b = SYNC_SECOND;
      6'd2:  b = FRAME_VERSION;
      6'd3:  b = PAYLOAD_LEN;
      6'd4:  b = rec.tick[7:0];
      6'd5:  b = rec.tick[15:8];
      6'd6:  b = rec.tick[23:16];
      6'd7:  b = rec.tick[31:24];
      6'd8:  b = rec.chamber_temp[7:0];
      6'd9:  b = rec.chamber_temp[15:8];
      6'd10: b = rec.chamber_temp[23:16];
      6'd11: b = rec.chamber_temp[31:24];
      6'd12: b = rec.ambient_ofs;
      6'd16: b = rec.humidity[7:0];
      6'd17: b = rec.humidity[15:8];
      6'd18: b = {7'd0, rec.humidity[16]};
      6'd20: b = {7'd0, rec.reading_valid};
      6'd21: b = rec.status;
      6'd22: b = rec.heater[7:0];
      6'd23: b = {6'd0, rec.heater[9:8]};
      6'd24: b = rec.set_temp;
      6'd25: b = {1'b0, rec.set_hum};
      6'd26: b = rec.fault;
      6'd27: b = rec.ack_outcome;
      6'd28: b = rec.ack_sess_id[7:0];
      6'd29: b = rec.ack_sess_id[15:8];
      6'd30: b = rec.ack_sess_id[23:16];
      6'd31: b = rec.ack_sess_id[31:24];
      6'd32: b = rec.ack_seq_no[7:0];
      6'd33: b = rec.ack_seq_no[15:8];
      6'd34: b = rec.ack_seq_no[23:16];
      6'd35: b = rec.ack_seq_no[31:24];
      6'd36: b = rec.rcv_err_cnt[7:0];
      6'd37: b = rec.rcv_err_cnt[15:8];
      6'd38: b = rec.rcv_err_cnt[23:16];
      6'd39: b = rec.rcv_err_cnt[31:24];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/tfb_front.sv =====
module tfb_front
  import tfb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  input  logic [31:0]        in_tick_count,
  input  logic signed [31:0] in_chamber_temperature,
  input  logic signed [7:0]  in_ambient_temperature,
  input  logic [16:0]        in_humidity_level,
  input  logic               in_reading_valid,
  input  logic [7:0]         in_status_flags,
  input  logic [9:0]         in_heater_output,
  input  logic [7:0]         in_fault_code,
  input  logic [7:0]         in_ack_outcome,
  input  logic [31:0]        in_ack_session_id,
  input  logic [31:0]        in_ack_sequence_no,
  input  logic [31:0]        in_receive_errors,
  output logic               push,
  output record_t            push_rec,
  input  logic               q_full
);

  logic [7:0] set_temp_r, set_temp_nxt;
  logic [6:0] set_hum_r, set_hum_nxt;

  always_comb begin
    set_temp_nxt = set_temp_r;
    set_hum_nxt  = set_hum_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_TARGET_TEMP: set_temp_nxt = cfg_wdata;
        CFG_TARGET_HUM:  set_hum_nxt  = cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_temp_r <= '0;
      set_hum_r  <= '0;
    end else begin
      set_temp_r <= set_temp_nxt;
      set_hum_r  <= set_hum_nxt;
    end
  end

  assign push = in_valid && !q_full;

  always_comb begin
    push_rec.tick          = in_tick_count;
    push_rec.chamber_temp  = $unsigned(in_chamber_temperature);
    push_rec.ambient_ofs   = $unsigned(in_ambient_temperature) + AMBIENT_OFFSET;
    push_rec.humidity      = (in_humidity_level > HUMIDITY_MAX) ? HUMIDITY_MAX
                                                                : in_humidity_level;
    push_rec.reading_valid = in_reading_valid;
    push_rec.status        = in_status_flags;
    push_rec.heater        = (in_heater_output > OUTPUT_MAX) ? OUTPUT_MAX : in_heater_output;
    push_rec.set_temp      = set_temp_r;
    push_rec.set_hum       = (set_hum_r > SETPOINT_HUM_MAX) ? SETPOINT_HUM_MAX : set_hum_r;
    push_rec.fault         = in_fault_code;
    push_rec.ack_outcome   = in_ack_outcome;
    push_rec.ack_sess_id   = in_ack_session_id;
    push_rec.ack_seq_no    = in_ack_sequence_no;
    push_rec.rcv_err_cnt   = in_receive_errors;
  end

endmodule

// ===== sv/tfb_queue.sv =====
module tfb_queue
  import tfb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  record_t push_rec,
  output logic    q_full,
  output logic    q_valid,
  output record_t q_rec,
  input  logic    pop
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  record_t          slot_r [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   count_r, count_nxt;

  assign q_full  = (count_r == QCW'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_rec   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

// ===== sv/tfb_back.sv =====
module tfb_back
  import tfb_pkg::*;
#(
  parameter int FRAME_LENGTH = FRAME_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  record_t    q_rec,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_frame_byte,
  output logic       out_last_byte
);

  localparam int PW = $clog2(FRAME_LENGTH);

  record_t        rec_r, rec_nxt;
  logic           busy_r, busy_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic [15:0]    crc_r, crc_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     byte_r, byte_nxt;
  logic           last_r, last_nxt;

  logic           load;
  logic           is_last;
  logic           is_crc_lo;
  logic [7:0]     data_byte;

  assign load      = busy_r && (!out_valid_r || !out_stall);
  assign is_last   = (pos_r == PW'(FRAME_LENGTH - 1));
  assign is_crc_lo = (pos_r == PW'(FRAME_LENGTH - 2));
  assign pop       = q_valid && (!busy_r || (load && is_last));

  always_comb begin
    if (pos_r < PW'(PAYLOAD_END)) begin
      data_byte = record_byte(rec_r, pos_r[5:0]);
    end else begin
      data_byte = 8'd0;
    end
  end

  always_comb begin
    rec_nxt       = rec_r;
    busy_nxt      = busy_r;
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    if (out_stall == 1'b0) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      last_nxt      = is_last;
      if (is_last) begin
        byte_nxt = crc_r[15:8];
        crc_nxt  = CRC_INIT;
        pos_nxt  = '0;
        busy_nxt = 1'b0;
      end else if (is_crc_lo) begin
        byte_nxt = crc_r[7:0];
        pos_nxt  = pos_r + 1'b1;
      end else begin
        byte_nxt = data_byte;
        crc_nxt  = crc_byte(crc_r, data_byte);
        pos_nxt  = pos_r + 1'b1;
      end
    end
    if (pop) begin
      rec_nxt  = q_rec;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pos_r       <= '0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r  <= rec_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = byte_r;
  assign out_last_byte  = last_r;

  a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (pos_r == '0 && crc_r == CRC_INIT))
    else $error("serializer idle with frame state left over");

  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (load && is_last) |=> (pos_r == '0 && crc_r == CRC_INIT))
    else $error("frame end did not rewind position and crc");

  a_pop_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !(load && is_last)) |-> !pop)
    else $error("record taken while frame in progress");

endmodule

// ===== sv/telemetry_frame_builder_crc16.sv =====
// telemetry frame builder, crc-16/ccitt-false
//
// in_*  : one telemetry record per beat, valid/stall handshake; the record is
//         saturated and packed on entry and parked in a two-entry queue, so
//         in_stall rises only when both queue slots are taken
// out_* : the frame, one byte per beat, out_last_byte on the final crc byte;
//         each record gives FRAME_LENGTH bytes (64 by default)
// cfg_* : setpoint registers (index 0 temperature, index 1 humidity), taken
//         at the values in force when a record enters; cfg_ready is always high
//
// the first byte of a frame reaches out_* through the queue slot, the serializer's record
// register and the output byte register. throughput: one frame byte per cycle while
// out_stall is low, set by the single-byte crc update in the serializer;
// the next queued record starts right behind the last byte of the previous one
// out_stall with out_valid high holds the current byte and freezes the serializer; the queue
// keeps taking records until full
// reset (rst_n low, synchronous) empties the queue, clears the setpoints and
// restarts the crc at 0xFFFF
module telemetry_frame_builder_crc16
  import tfb_pkg::*;
#(
  parameter int FRAME_LENGTH = FRAME_LENGTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_tick_count,
  input  logic signed [31:0] in_chamber_temperature,
  input  logic signed [7:0]  in_ambient_temperature,
  input  logic [16:0]        in_humidity_level,
  input  logic               in_reading_valid,
  input  logic [7:0]         in_status_flags,
  input  logic [9:0]         in_heater_output,
  input  logic [7:0]         in_fault_code,
  input  logic [7:0]         in_ack_outcome,
  input  logic [31:0]        in_ack_session_id,
  input  logic [31:0]        in_ack_sequence_no,
  input  logic [31:0]        in_receive_errors,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_frame_byte,
  output logic               out_last_byte
);

  logic    push;
  record_t push_rec;
  logic    q_full;
  logic    q_valid;
  record_t q_rec;
  logic    pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  tfb_front u_front (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_valid              (cfg_valid),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_tick_count          (in_tick_count),
    .in_chamber_temperature (in_chamber_temperature),
    .in_ambient_temperature (in_ambient_temperature),
    .in_humidity_level      (in_humidity_level),
    .in_reading_valid       (in_reading_valid),
    .in_status_flags        (in_status_flags),
    .in_heater_output       (in_heater_output),
    .in_fault_code          (in_fault_code),
    .in_ack_outcome         (in_ack_outcome),
    .in_ack_session_id      (in_ack_session_id),
    .in_ack_sequence_no     (in_ack_sequence_no),
    .in_receive_errors      (in_receive_errors),
    .push                   (push),
    .push_rec               (push_rec),
    .q_full                 (q_full)
  );

  tfb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .q_full   (q_full),
    .q_valid  (q_valid),
    .q_rec    (q_rec),
    .pop      (pop)
  );

  tfb_back #(
    .FRAME_LENGTH (FRAME_LENGTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_rec          (q_rec),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

endmodule
